/* src/gbma_pkg.sv */
// Shared constants, codes and pipeline types of the guarded byte memory access unit.
package gbma_pkg;

    // Store geometry: four byte-wide banks, one per address low-bit pattern
    localparam int MEM_BYTES  = 65536;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_DEPTH = MEM_BYTES / NUM_BANKS;
    localparam int ROW_W      = $clog2(BANK_DEPTH);

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 32;
    localparam int GUARD_W = 16;
    localparam int LIMIT_W = 17;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    // Register values after reset
    localparam logic [GUARD_W-1:0] STACK_START_RST = GUARD_W'(32768);
    localparam logic [LIMIT_W-1:0] MEM_SIZE_RST    = LIMIT_W'(65536);

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // Access size codes; the fourth code is always refused
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_NONE = 2'd3
    } t_size;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STACK_START = 1'b0,
        REG_MEM_SIZE    = 1'b1
    } t_cfg_idx;

    // Input register contents
    typedef struct packed {
        logic              valid;
        t_op               op;
        t_size             size;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_s1;

    // Memory stage contents, used to assemble the result
    typedef struct packed {
        logic       valid;
        logic       error;
        logic       rd;
        logic [1:0] off;
        logic [2:0] nbytes;
    } t_s2;

endpackage

/* src/gbma_ram.sv */
// Generic single-port RAM with registered read data.
module gbma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* src/guarded_byte_memory_access_unit.sv */
// Top level: guarded, byte-addressed, little-endian memory with unaligned access.
//
//  channel   | signals                                          | handshake
//  ----------+--------------------------------------------------+---------------------------
//  access in | i_operation i_access_size i_address i_write_data | start && !busy
//  result    | o_read_data o_error                              | o_valid, one cycle, no stall
//  config    | i_cfg_index i_cfg_wdata                          | i_cfg_we
//
//  One access per cycle while busy is low. Results pass through the input
//  register, bank access and result register.
//  The store is four byte banks; each access touches each bank at most once, so
//  unaligned accesses of up to four bytes need only one access to each bank.
//  After reset the banks are cleared one row a cycle, MEM_BYTES/4 = 16384 rows; busy
//  stays high until the last row is cleared. Configuration writes are taken at any time.
//  The receiver cannot stall; nothing in the pipeline waits.
module guarded_byte_memory_access_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_operation,
    input  logic [1:0]                     i_access_size,
    input  logic [gbma_pkg::ADDR_W-1:0]    i_address,
    input  logic [gbma_pkg::DATA_W-1:0]    i_write_data,
    output logic                           o_valid,
    output logic [gbma_pkg::DATA_W-1:0]    o_read_data,
    output logic                           o_error,
    input  logic                           i_cfg_we,
    input  logic [gbma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbma_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gbma_pkg::*;

    logic                accept;
    t_s1                 r_s1, n_s1;
    t_s2                 r_s2, n_s2;
    logic [GUARD_W-1:0]  r_stack_start;
    logic [LIMIT_W-1:0]  r_mem_size;
    logic                r_clearing;
    logic [ROW_W-1:0]    r_clr_row;
    logic [LIMIT_W-1:0]  last;
    logic [2:0]          nbytes;
    logic                refused;
    logic [DATA_W-1:0]   n_read_data;
    logic                ram_we    [NUM_BANKS];
    logic [ROW_W-1:0]    ram_addr  [NUM_BANKS];
    logic [7:0]          ram_wdata [NUM_BANKS];
    logic [7:0]          ram_rdata [NUM_BANKS];

    assign busy   = r_clearing;
    assign accept = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_start <= STACK_START_RST;
            r_mem_size    <= MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_STACK_START: r_stack_start <= i_cfg_wdata[GUARD_W-1:0];
                REG_MEM_SIZE:    r_mem_size    <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing pass after reset, one row of all banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(BANK_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Input register
    always_comb begin
        n_s1.valid = accept;
        n_s1.op    = t_op'(i_operation);
        n_s1.size  = t_size'(i_access_size);
        n_s1.addr  = i_address;
        n_s1.wdata = i_write_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.op    <= n_s1.op;
        r_s1.size  <= n_s1.size;
        r_s1.addr  <= n_s1.addr;
        r_s1.wdata <= n_s1.wdata;
    end

    // Range and guard check on the registered item
    always_comb begin
        case (r_s1.size)
            SZ_BYTE: nbytes = 3'd1;
            SZ_HALF: nbytes = 3'd2;
            SZ_WORD: nbytes = 3'd4;
            default: nbytes = 3'd0;
        endcase
        // last byte index, no wrap past the address range
        last = LIMIT_W'(r_s1.addr) + LIMIT_W'((nbytes == 3'd0) ? 3'd0 : (nbytes - 3'd1));
        refused = (r_s1.size == SZ_NONE)
               || ((r_s1.addr <= r_stack_start) && (last >= LIMIT_W'(r_stack_start)))
               || (last >= r_mem_size)
               || (32'(last) >= 32'(MEM_BYTES));
    end

    // Byte banks: bank b holds the bytes whose address ends in b
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [1:0]       lane;
        logic [ROW_W-1:0] row;

        always_comb begin
            lane = 2'(b) - r_s1.addr[1:0];
            // banks below the start offset take the next row
            row  = r_s1.addr[ADDR_W-1:2] + ROW_W'(2'(b) < r_s1.addr[1:0]);
            if (r_clearing) begin
                ram_we[b]    = 1'b1;
                ram_addr[b]  = r_clr_row;
                ram_wdata[b] = '0;
            end else begin
                ram_we[b]    = r_s1.valid && !refused && (r_s1.op == OP_WRITE)
                            && ({1'b0, lane} < nbytes);
                ram_addr[b]  = row;
                ram_wdata[b] = r_s1.wdata[{lane, 3'b000} +: 8];
            end
        end

        gbma_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (ram_we[b]),
            .i_addr  (ram_addr[b]),
            .i_wdata (ram_wdata[b]),
            .o_rdata (ram_rdata[b])
        );
    end

    // Memory stage register
    always_comb begin
        n_s2.valid  = r_s1.valid;
        n_s2.error  = refused;
        n_s2.rd     = !refused && (r_s1.op == OP_READ);
        n_s2.off    = r_s1.addr[1:0];
        n_s2.nbytes = nbytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.error  <= n_s2.error;
        r_s2.rd     <= n_s2.rd;
        r_s2.off    <= n_s2.off;
        r_s2.nbytes <= n_s2.nbytes;
    end

    // Rotate bank bytes into little-endian order, zero-extend
    always_comb begin
        for (int i = 0; i < NUM_BANKS; i++) begin
            n_read_data[8*i +: 8] = (r_s2.rd && (3'(i) < r_s2.nbytes))
                                  ? ram_rdata[2'(r_s2.off + 2'(i))] : 8'h00;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s2.valid;
        end
        o_read_data <= n_read_data;
        o_error     <= r_s2.error;
    end

endmodule

/* src/gbma_checker.sv */
// Port-level checks of the guarded byte memory access unit, bound to the top level.
module gbma_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_operation,
    input logic [1:0]                     i_access_size,
    input logic                           o_valid,
    input logic [gbma_pkg::DATA_W-1:0]    o_read_data,
    input logic                           o_error
);
    import gbma_pkg::*;

    // Clearing pass starts right after reset
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // Every accepted item gives one result after the input, memory stage and result registers
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three cycles after accept");

    // Refused accesses read as zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_read_data == '0))
        else $error("refused access returned data");

    // The unused size code is always refused
    a_bad_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_access_size == SZ_NONE)) |-> ##3 o_error)
        else $error("bad size code not refused");

    // Writes return zero data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_WRITE)) |-> ##3 (o_read_data == '0))
        else $error("write returned data");

endmodule

bind guarded_byte_memory_access_unit gbma_checker u_gbma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .i_access_size (i_access_size),
    .o_valid       (o_valid),
    .o_read_data   (o_read_data),
    .o_error       (o_error)
);
